// ===== rtl/core/usr_pkg.sv =====
// shared types, constants and helpers of the slice reorder and reassembly block
package usr_pkg;

	localparam int WINDOW_ENTRIES_DEF = 16;
	localparam int MAX_SLICES_DEF     = 256;
	localparam int RESULT_CAP         = 16;
	localparam int CFG_IDX_W          = 1;
	localparam int CFG_DATA_W         = 16;

	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT    = 1'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_INTERVAL = 1'(1);

	typedef enum logic [1:0] {
		KIND_DELIVER = 2'd0,
		KIND_RANGE   = 2'd1,
		KIND_MASK    = 2'd2
	} kind_t;

	typedef struct packed {
		logic [31:0] slice_seq;
		logic [8:0]  slice_count;
		logic [7:0]  slice_index;
		logic [31:0] now_time;
	} slice_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [31:0] result_seq;
		logic [31:0] result_seq_end;
		logic [2:0]  mask_index;
		logic [31:0] mask_word;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [31:0] seq;
		logic [8:0]  slices;
		logic [8:0]  rcnt;
	} meta_t;

	// a strictly after b, with wraparound
	function automatic logic seq_after(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = b - a;
		return d[31];
	endfunction

endpackage

// ===== rtl/core/usr_mem.sv =====
// single write port, single registered read port memory
module usr_mem #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/udp_slice_reorder_reassembly.sv =====
// reorder and reassembly window for sliced packets: sequencer around two memories
//
//   channel   signals                         direction  handshake
//   config    cfg_we, cfg_index, cfg_wdata    in         write when cfg_we high
//   slice     start, busy, slice              in         beat when start and not busy
//   result    result_valid, result            out        one-cycle strobe, no stall
//
// the search visits the held entries one by one through the single read port of the entry
// metadata memory; delivered packets, mask words and abandoned entries are handled one at a time.
// reset clears the window, counters and registers at once; no clearing pass.
// results leave as strobes the receiver cannot hold off; busy is high while a slice is in work.
module udp_slice_reorder_reassembly #(
	parameter int WINDOW_ENTRIES = usr_pkg::WINDOW_ENTRIES_DEF,
	parameter int MAX_SLICES     = usr_pkg::MAX_SLICES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [usr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [usr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            start,
	output logic                            busy,
	input  usr_pkg::slice_t                 slice,
	output logic                            result_valid,
	output usr_pkg::result_t                result
);
	import usr_pkg::*;

	localparam int W   = WINDOW_ENTRIES;
	localparam int M   = MAX_SLICES;
	localparam int SW  = $clog2(W);
	localparam int HW  = $clog2(W + 1);
	localparam int MW  = (M + 63) / 64;
	localparam int NW  = (M + 31) / 32;
	localparam int MWB = (MW > 1) ? $clog2(MW) : 1;
	localparam int MD  = W * MW;
	localparam int MAW = $clog2(MD);
	localparam int MTW = $bits(meta_t);
	localparam int NB  = $clog2(RESULT_CAP + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_EVICT, S_NEW, S_CLR, S_FRD, S_FWR, S_CRD,
		S_CHK, S_AB_RD, S_AB, S_MRD, S_MLO, S_MHI, S_DRD, S_DR
	} state_t;

	state_t          state_q;
	logic [HW-1:0]   k_q, pk_q, pos_q, held_q;
	logic            pv_q, posf_q;
	logic [SW-1:0]   pslot_q, fslot_q;
	logic [8:0]      fslices_q, frcnt_q, cnt_q;
	logic [31:0]     seq_q, now_q, nrs_q, lrt_q;
	logic [7:0]      idx_q, rc_q, lim_q;
	logic [15:0]     ri_q;
	logic [W-1:0]    valid_q, done_q;
	logic [SW-1:0]   order_q [W];
	logic [MWB-1:0]  j_q;
	logic [NB-1:0]   n_q;
	result_t         res_q;
	logic            rvalid_q;

	logic            meta_re, meta_we;
	logic [SW-1:0]   meta_raddr, meta_waddr;
	meta_t           meta_wdata, meta_rd;
	logic [MTW-1:0]  meta_rbits;
	logic            mask_re, mask_we;
	logic [MAW-1:0]  mask_raddr, mask_waddr;
	logic [63:0]     mask_wdata, mask_rd;

	logic [HW-1:0]   pcnt, pamt, held_ev;
	logic [W-1:0]    valid_pop;
	logic [SW-1:0]   order_pop [W];
	logic [SW-1:0]   order_ins [W];
	logic [SW-1:0]   free_slot, front;
	logic            match_now, idx_ok, fidx_ok, drain_ok, elapsed, later_done;
	logic [8:0]      rcnt_new;
	logic [31:0]     mword, mhalf;
	int              wcur;
	logic [8:0]      cnt_in;

	function automatic logic [MAW-1:0] maddr(input logic [SW-1:0] s, input int w);
		return MAW'(int'(s) * MW + w);
	endfunction

	function automatic logic [63:0] new_word(input int w, input logic ok, input logic [7:0] ix);
		logic [63:0] v;
		v = '0;
		if (ok && (int'(ix >> 6) == w)) begin
			v[ix[5:0]] = 1'b1;
		end
		return v;
	endfunction

	usr_mem #(.WIDTH(MTW), .DEPTH(W)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (meta_raddr),
		.rdata (meta_rbits)
	);
	assign meta_rd = meta_t'(meta_rbits);

	usr_mem #(.WIDTH(64), .DEPTH(MD)) u_mask (
		.clk   (clk),
		.we    (mask_we),
		.waddr (mask_waddr),
		.wdata (mask_wdata),
		.re    (mask_re),
		.raddr (mask_raddr),
		.rdata (mask_rd)
	);

	assign busy         = (state_q != S_IDLE);
	assign result_valid = rvalid_q;
	assign result       = res_q;
	assign front        = order_q[0];

	// clamp the slice count into 1..MAX_SLICES
	always_comb begin
		cnt_in = slice.slice_count;
		if (cnt_in == 9'd0) begin
			cnt_in = 9'd1;
		end else if (cnt_in > 9'(M)) begin
			cnt_in = 9'(M);
		end
	end

	assign pcnt     = (held_q >= HW'(W - 1)) ? held_q - HW'(W - 2) : '0;
	assign held_ev  = held_q - pcnt;
	assign pamt     = (state_q == S_EVICT) ? pcnt : HW'(1);
	assign match_now = pv_q && (meta_rd.seq == seq_q);
	assign idx_ok   = {1'b0, idx_q} < cnt_q;
	assign fidx_ok  = {1'b0, idx_q} < fslices_q;
	assign rcnt_new = idx_ok ? 9'd1 : 9'd0;
	assign drain_ok = (held_q != '0) && done_q[order_q[0]] && (n_q < NB'(RESULT_CAP));
	assign elapsed  = (now_q - lrt_q) >= {16'd0, ri_q};
	assign later_done = !done_q[front] && |(done_q & valid_q & ~(W'(1) << front));

	// pop from the front and insert the free slot at the position found by the scan
	always_comb begin
		valid_pop = valid_q;
		for (int k = 0; k < W; k++) begin
			if ((k < int'(pamt)) && (k < int'(held_q))) begin
				valid_pop[order_q[k]] = 1'b0;
			end
			if (k + int'(pamt) < W) begin
				order_pop[k] = order_q[SW'(k + int'(pamt))];
			end else begin
				order_pop[k] = order_q[k];
			end
			if (k < int'(pos_q)) begin
				order_ins[k] = order_q[k];
			end else if (k == int'(pos_q)) begin
				order_ins[k] = free_slot;
			end else begin
				order_ins[k] = order_q[SW'(k - 1)];
			end
		end
	end

	// lowest free slot
	always_comb begin
		free_slot = '0;
		for (int k = W - 1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_slot = SW'(k);
			end
		end
	end

	// missing-slice word from one half of the stored mask word
	always_comb begin
		wcur  = 2 * int'(j_q) + ((state_q == S_MHI) ? 1 : 0);
		mhalf = (state_q == S_MHI) ? mask_rd[63:32] : mask_rd[31:0];
		mword = '0;
		for (int b = 0; b < 32; b++) begin
			if ((wcur * 32 + b < int'(fslices_q)) && !mhalf[b]) begin
				mword[b] = 1'b1;
			end
		end
	end

	// memory port control
	always_comb begin
		meta_re    = 1'b0;
		meta_raddr = order_q[0];
		meta_we    = 1'b0;
		meta_waddr = free_slot;
		meta_wdata = '{seq: seq_q, slices: cnt_q, rcnt: rcnt_new};
		mask_re    = 1'b0;
		mask_raddr = maddr(fslot_q, int'(idx_q >> 6));
		mask_we    = 1'b0;
		mask_waddr = maddr(free_slot, 0);
		mask_wdata = new_word(0, idx_ok, idx_q);
		unique case (state_q)
			S_SCAN: begin
				meta_re    = (k_q < held_q) && !match_now;
				meta_raddr = order_q[k_q[SW-1:0]];
			end
			S_NEW: begin
				meta_we = 1'b1;
				mask_we = 1'b1;
			end
			S_CLR: begin
				mask_we    = 1'b1;
				mask_waddr = maddr(fslot_q, int'(j_q));
				mask_wdata = new_word(int'(j_q), idx_ok, idx_q);
			end
			S_FRD: begin
				mask_re = fidx_ok;
			end
			S_FWR: begin
				meta_we    = !mask_rd[idx_q[5:0]];
				meta_waddr = fslot_q;
				meta_wdata = '{seq: seq_q, slices: fslices_q, rcnt: frcnt_q + 9'd1};
				mask_we    = !mask_rd[idx_q[5:0]];
				mask_waddr = maddr(fslot_q, int'(idx_q >> 6));
				mask_wdata = mask_rd | (64'd1 << idx_q[5:0]);
			end
			S_CRD, S_AB_RD: begin
				meta_re = 1'b1;
			end
			S_DRD: begin
				meta_re = drain_ok;
			end
			S_MRD: begin
				mask_re    = 1'b1;
				mask_raddr = maddr(fslot_q, int'(j_q));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			k_q       <= '0;
			pk_q      <= '0;
			pos_q     <= '0;
			held_q    <= '0;
			pv_q      <= 1'b0;
			posf_q    <= 1'b0;
			pslot_q   <= '0;
			fslot_q   <= '0;
			fslices_q <= '0;
			frcnt_q   <= '0;
			cnt_q     <= '0;
			seq_q     <= '0;
			now_q     <= '0;
			nrs_q     <= '0;
			lrt_q     <= '0;
			idx_q     <= '0;
			rc_q      <= '0;
			lim_q     <= 8'd3;
			ri_q      <= 16'd50;
			valid_q   <= '0;
			done_q    <= '0;
			for (int k = 0; k < W; k++) begin
				order_q[k] <= '0;
			end
			j_q       <= '0;
			n_q       <= '0;
			res_q     <= '0;
			rvalid_q  <= 1'b0;
		end else begin
			rvalid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RETRY_LIMIT:    lim_q <= cfg_wdata[7:0];
					REG_RETRY_INTERVAL: ri_q  <= cfg_wdata;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						seq_q   <= slice.slice_seq;
						cnt_q   <= cnt_in;
						idx_q   <= slice.slice_index;
						now_q   <= slice.now_time;
						k_q     <= '0;
						pv_q    <= 1'b0;
						posf_q  <= 1'b0;
						n_q     <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// reads are issued one ahead of the compare
					pv_q    <= meta_re;
					pk_q    <= k_q;
					pslot_q <= order_q[k_q[SW-1:0]];
					if (meta_re) begin
						k_q <= k_q + HW'(1);
					end
					if (match_now) begin
						fslot_q   <= pslot_q;
						fslices_q <= meta_rd.slices;
						frcnt_q   <= meta_rd.rcnt;
						state_q   <= S_FRD;
					end else begin
						if (pv_q && (pk_q >= pcnt) && !posf_q
						    && seq_after(meta_rd.seq, seq_q)) begin
							pos_q  <= pk_q - pcnt;
							posf_q <= 1'b1;
						end
						if (k_q >= held_q) begin
							state_q <= S_EVICT;
						end
					end
				end
				S_EVICT: begin
					valid_q <= valid_pop;
					for (int k = 0; k < W; k++) begin
						order_q[k] <= order_pop[k];
					end
					held_q <= held_ev;
					if (!posf_q) begin
						pos_q <= held_ev;
					end
					if ((held_ev != '0) && seq_after(nrs_q, seq_q)) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_NEW;
					end
				end
				S_NEW: begin
					valid_q[free_slot] <= 1'b1;
					done_q[free_slot]  <= (rcnt_new == cnt_q);
					for (int k = 0; k < W; k++) begin
						order_q[k] <= order_ins[k];
					end
					held_q  <= held_q + HW'(1);
					fslot_q <= free_slot;
					j_q     <= MWB'(1);
					state_q <= (MW > 1) ? S_CLR : S_CRD;
				end
				S_CLR: begin
					j_q <= j_q + MWB'(1);
					if (int'(j_q) == MW - 1) begin
						state_q <= S_CRD;
					end
				end
				S_FRD: begin
					state_q <= fidx_ok ? S_FWR : S_CRD;
				end
				S_FWR: begin
					if (!mask_rd[idx_q[5:0]]) begin
						done_q[fslot_q] <= ((frcnt_q + 9'd1) == fslices_q);
					end
					state_q <= S_CRD;
				end
				S_CRD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (rc_q < lim_q) begin
						if (nrs_q != meta_rd.seq) begin
							if (elapsed) begin
								lrt_q    <= now_q;
								rc_q     <= rc_q + 8'd1;
								rvalid_q <= 1'b1;
								res_q    <= '{result_kind: KIND_RANGE, result_seq: nrs_q,
									result_seq_end: meta_rd.seq, mask_index: 3'd0,
									mask_word: 32'd0, last: 1'b1};
							end
							state_q <= S_IDLE;
						end else if (later_done && elapsed) begin
							lrt_q     <= now_q;
							rc_q      <= rc_q + 8'd1;
							fslot_q   <= front;
							fslices_q <= meta_rd.slices;
							seq_q     <= meta_rd.seq;
							j_q       <= '0;
							state_q   <= S_MRD;
						end else begin
							state_q <= S_DRD;
						end
					end else begin
						state_q <= S_AB;
					end
				end
				S_AB_RD: begin
					state_q <= S_AB;
				end
				S_AB: begin
					// retry limit reached: drop incomplete entries at the front
					nrs_q <= meta_rd.seq + 32'd1;
					if (done_q[front]) begin
						rc_q    <= '0;
						state_q <= S_DRD;
					end else begin
						valid_q <= valid_pop;
						for (int k = 0; k < W; k++) begin
							order_q[k] <= order_pop[k];
						end
						held_q <= held_q - HW'(1);
						if (held_q == HW'(1)) begin
							rc_q    <= '0;
							state_q <= S_DRD;
						end else begin
							state_q <= S_AB_RD;
						end
					end
				end
				S_MRD: begin
					state_q <= S_MLO;
				end
				S_MLO, S_MHI: begin
					rvalid_q <= 1'b1;
					res_q    <= '{result_kind: KIND_MASK, result_seq: seq_q,
						result_seq_end: 32'd0, mask_index: 3'(wcur),
						mask_word: mword, last: (wcur == NW - 1)};
					if (wcur == NW - 1) begin
						state_q <= S_IDLE;
					end else if (state_q == S_MLO) begin
						state_q <= S_MHI;
					end else begin
						j_q     <= j_q + MWB'(1);
						state_q <= S_MRD;
					end
				end
				S_DRD: begin
					state_q <= drain_ok ? S_DR : S_IDLE;
				end
				S_DR: begin
					rvalid_q <= 1'b1;
					res_q    <= '{result_kind: KIND_DELIVER, result_seq: meta_rd.seq,
						result_seq_end: 32'd0, mask_index: 3'd0, mask_word: 32'd0,
						last: !((held_q > HW'(1)) && done_q[order_q[1]]
							&& (n_q + NB'(1) < NB'(RESULT_CAP)))};
					valid_q <= valid_pop;
					for (int k = 0; k < W; k++) begin
						order_q[k] <= order_pop[k];
					end
					held_q  <= held_q - HW'(1);
					nrs_q   <= meta_rd.seq + 32'd1;
					rc_q    <= '0;
					n_q     <= n_q + NB'(1);
					state_q <= S_DRD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HW'(W - 1))
		else $error("window holds too many entries");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(held_q))
		else $error("valid slots disagree with held count");

	a_result_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_q |-> $past(state_q != S_IDLE))
		else $error("result strobe without a slice in work");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");
`endif

endmodule
